/* rtl/frm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frm_pkg: shared types and constants of the frame rate meter and limiter
// Field widths, fixed arithmetic constants, sequencer states and the
// period ring control bundle.
// ----------------------------------------------------------------------------
package frm_pkg;

  // Field widths
  localparam int TS_W    = 32;
  localparam int RATE_W  = 22;
  localparam int DELAY_W = 10;
  localparam int MAXR_W  = 10;

  // Operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_END   = 1'b1;

  // Arithmetic constants
  localparam logic [MAXR_W-1:0]  MAX_RATE_RST = 10'd60;
  localparam int                 TGT_NUM      = 1000;     // ms per second
  localparam int                 RATE_SCALE   = 256000;   // 1000 in Q8
  localparam logic [RATE_W-1:0]  RATE_MAX     = 22'h3FFFFF;
  localparam logic [RATE_W-1:0]  RATE_DEFAULT = 22'd15360; // 60.0 in Q8

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_ADD,
    ST_TGT,
    ST_RATE,
    ST_OUT
  } state_e;

  // Period ring control
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ring_ctl_t;

endpackage
`default_nettype wire

/* rtl/frm_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frm_div: shared restoring divider
// One quotient bit per cycle; when the quotient is final, done_o pulses
// for one cycle. A start in the done cycle is taken.
// ----------------------------------------------------------------------------
module frm_div #(
  parameter int NUM_W = 22,
  parameter int DEN_W = 36
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             run_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W:0]   trial;
  logic             ge;

  // One shift-subtract step
  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    ge    = (trial >= {1'b0, den_q});
    rem_d = ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
    quo_d = {quo_q[NUM_W-2:0], ge};
  end

  assign done_o = run_q && (cnt_q == '0);
  assign quot_o = quo_q;

  // Step counter and run flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= CNT_W'(NUM_W);
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (run_q && (cnt_q != '0)) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/frm_ring.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frm_ring: ring of the most recent frame periods
// Single-port memory with a registered read and a wrapping write slot.
// A write stores at the current slot and advances it.
// ----------------------------------------------------------------------------
module frm_ring #(
  parameter int DEPTH = 10
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire frm_pkg::ring_ctl_t      ctl_i,
  input  wire logic [frm_pkg::TS_W-1:0] wdata_i,
  output logic [frm_pkg::TS_W-1:0]     rdata_o
);

  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [frm_pkg::TS_W-1:0] mem [DEPTH];
  logic [frm_pkg::TS_W-1:0] rdata_q;
  logic [SLOT_W-1:0]        slot_q;

  // Write slot, wraps after the last entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (ctl_i.wr_en) begin
      slot_q <= (slot_q == SLOT_W'(DEPTH - 1)) ? '0 : slot_q + 1'b1;
    end
  end

  // Memory port
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[slot_q] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem[slot_q];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* rtl/frame_rate_meter_and_limiter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_rate_meter_and_limiter: averaged frame rate and frame limiter delay
// Input channel (in_valid_i/in_ready_o) carries a start or end mark with a
// millisecond timestamp. A start mark leaves the input open and gives no
// result. An end mark gives one request on the output channel
// (out_valid_o/out_ready_i): averaged rate in Q8, delay to hold max_rate,
// and the period since the previous end mark.
// An end mark runs through a small sequencer around one shared restoring
// divider: ring read, sum update, target division (1000 / max_rate), then
// rate division (count * 256000 / sum); the rate division is skipped when
// the sum is zero. in_ready_o is low until the sequencer is back in idle.
// The finished result sits in an output register; a new item is accepted
// while it waits, and the next end mark holds in the last sequencer state
// until the receiver takes the previous result.
// max_rate is written through cfg_we_i/cfg_wdata_i; the user must write it
// only while idle, the block does not enforce this.
// Reset clears the window, sum and times and sets max_rate to 60.
// ----------------------------------------------------------------------------
module frame_rate_meter_and_limiter #(
  parameter int WINDOW = 10
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [frm_pkg::MAXR_W-1:0]    cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          operation_i,
  input  wire logic [frm_pkg::TS_W-1:0]      timestamp_ms_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [frm_pkg::RATE_W-1:0]         rate_q8_o,
  output logic [frm_pkg::DELAY_W-1:0]        delay_ms_o,
  output logic [frm_pkg::TS_W-1:0]           frame_time_ms_o
);

  localparam int TS_W  = frm_pkg::TS_W;
  localparam int SUM_W = TS_W + $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int NUM_W = $clog2(WINDOW * frm_pkg::RATE_SCALE + 1);
  localparam int QW    = (NUM_W > frm_pkg::RATE_W) ? NUM_W : frm_pkg::RATE_W;

  frm_pkg::state_e    state_q, state_d;
  frm_pkg::ring_ctl_t ring_ctl;

  logic [frm_pkg::MAXR_W-1:0]  max_rate_q;
  logic [TS_W-1:0]             start_q, last_end_q, period_q, elapsed_q;
  logic                        seen_q;
  logic [SUM_W-1:0]            sum_q;
  logic [CNT_W-1:0]            held_q;
  logic [frm_pkg::RATE_W-1:0]  rate_q;
  logic [frm_pkg::DELAY_W-1:0] delay_q;
  logic                        out_valid_q;
  logic [frm_pkg::RATE_W-1:0]  out_rate_q;
  logic [frm_pkg::DELAY_W-1:0] out_delay_q;
  logic [TS_W-1:0]             out_time_q;

  logic                        accept, accept_end, accept_start, full, load_out;
  logic [frm_pkg::MAXR_W-1:0]  rate_div;
  logic [TS_W-1:0]             rd_data, tgt_ext;
  logic                        div_start, div_done;
  logic [NUM_W-1:0]            div_num, div_quot;
  logic [SUM_W-1:0]            div_den;
  logic [QW-1:0]               quot_ext;
  logic [frm_pkg::RATE_W-1:0]  rate_sat;
  logic [frm_pkg::DELAY_W-1:0] delay_calc;

  // Handshake and decode
  assign in_ready_o   = (state_q == frm_pkg::ST_IDLE);
  assign accept       = in_valid_i && in_ready_o;
  assign accept_end   = accept && (operation_i == frm_pkg::OP_END);
  assign accept_start = accept && (operation_i == frm_pkg::OP_START);
  assign full         = (held_q == CNT_W'(WINDOW));
  assign load_out     = (state_q == frm_pkg::ST_OUT) && (!out_valid_q || out_ready_i);
  assign rate_div     = (max_rate_q == '0) ? frm_pkg::MAXR_W'(1) : max_rate_q;

  // Result shaping from the divider
  always_comb begin
    quot_ext   = QW'(div_quot);
    rate_sat   = (quot_ext > QW'(frm_pkg::RATE_MAX)) ? frm_pkg::RATE_MAX
                                                     : quot_ext[frm_pkg::RATE_W-1:0];
    tgt_ext    = TS_W'(div_quot[frm_pkg::DELAY_W-1:0]);
    delay_calc = (elapsed_q < tgt_ext) ? frm_pkg::DELAY_W'(tgt_ext - elapsed_q) : '0;
  end

  // Sequencer: next state and strobes
  always_comb begin
    state_d        = state_q;
    ring_ctl.rd_en = 1'b0;
    ring_ctl.wr_en = 1'b0;
    div_start      = 1'b0;
    div_num        = NUM_W'(frm_pkg::TGT_NUM);
    div_den        = SUM_W'(rate_div);
    case (state_q)
      frm_pkg::ST_IDLE: begin
        ring_ctl.rd_en = accept_end;
        if (accept_end) begin
          state_d = frm_pkg::ST_SUB;
        end
      end
      frm_pkg::ST_SUB: begin
        state_d = frm_pkg::ST_ADD;
      end
      frm_pkg::ST_ADD: begin
        ring_ctl.wr_en = 1'b1;
        div_start      = 1'b1;
        state_d        = frm_pkg::ST_TGT;
      end
      frm_pkg::ST_TGT: begin
        if (div_done) begin
          if (sum_q == '0) begin
            state_d = frm_pkg::ST_OUT;
          end else begin
            div_start = 1'b1;
            div_num   = NUM_W'(held_q) * NUM_W'(frm_pkg::RATE_SCALE);
            div_den   = sum_q;
            state_d   = frm_pkg::ST_RATE;
          end
        end
      end
      frm_pkg::ST_RATE: begin
        if (div_done) begin
          state_d = frm_pkg::ST_OUT;
        end
      end
      frm_pkg::ST_OUT: begin
        if (load_out) begin
          state_d = frm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = frm_pkg::ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rate_q <= frm_pkg::MAX_RATE_RST;
    end else if (cfg_we_i) begin
      max_rate_q <= cfg_wdata_i;
    end
  end

  // Meter state: times, running sum, fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= '0;
      last_end_q <= '0;
      seen_q     <= 1'b0;
      sum_q      <= '0;
      held_q     <= '0;
    end else begin
      if (accept_start) begin
        start_q <= timestamp_ms_i;
      end
      if (accept_end) begin
        last_end_q <= timestamp_ms_i;
        seen_q     <= 1'b1;
      end
      if ((state_q == frm_pkg::ST_SUB) && full) begin
        sum_q <= sum_q - SUM_W'(rd_data);
      end
      if (state_q == frm_pkg::ST_ADD) begin
        sum_q <= sum_q + SUM_W'(period_q);
        if (!full) begin
          held_q <= held_q + 1'b1;
        end
      end
    end
  end

  // Per-item working registers
  always_ff @(posedge clk_i) begin
    if (accept_end) begin
      period_q  <= seen_q ? (timestamp_ms_i - last_end_q) : '0;
      elapsed_q <= timestamp_ms_i - start_q;
    end
    if ((state_q == frm_pkg::ST_TGT) && div_done) begin
      delay_q <= delay_calc;
      if (sum_q == '0) begin
        rate_q <= frm_pkg::RATE_DEFAULT;
      end
    end
    if ((state_q == frm_pkg::ST_RATE) && div_done) begin
      rate_q <= rate_sat;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_rate_q  <= rate_q;
      out_delay_q <= delay_q;
      out_time_q  <= period_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign rate_q8_o       = out_rate_q;
  assign delay_ms_o      = out_delay_q;
  assign frame_time_ms_o = out_time_q;

  // Period ring
  frm_ring #(
    .DEPTH (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ring_ctl),
    .wdata_i (period_q),
    .rdata_o (rd_data)
  );

  // Shared divider
  frm_div #(
    .NUM_W (NUM_W),
    .DEN_W (SUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

endmodule
`default_nettype wire

/* rtl/frm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frm_checker: port-level checks of the frame rate meter and limiter
// Watches the top level's channels and flags sequencing slips.
// ----------------------------------------------------------------------------
module frm_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic                          operation_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic [frm_pkg::DELAY_W-1:0]   delay_ms_o
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // An end mark starts the sequencer, so the input closes next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (operation_i == frm_pkg::OP_END) |=> !in_ready_o)
    else $error("input still open after end mark");

  // A start mark leaves the input open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (operation_i == frm_pkg::OP_START) |=> in_ready_o)
    else $error("start mark blocked the input");

  // Delay never exceeds one second
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (delay_ms_o <= frm_pkg::DELAY_W'(1000)))
    else $error("delay out of range");

endmodule

bind frame_rate_meter_and_limiter frm_checker u_frm_checker (.*);
`default_nettype wire

/* tb/frame_rate_meter_and_limiter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_rate_meter_and_limiter_tb: self-checking bench for the frame meter
// A table of start/end marks and max_rate writes runs first. Then come
// random phases of frame sequences, zero-period bursts, wrapping timestamps
// and noise. Each phase uses its own max_rate. An in-bench model of the
// period window predicts rate, delay and frame time for every end mark.
// Both handshakes see random gaps and stalls.
// ----------------------------------------------------------------------------
module frame_rate_meter_and_limiter_tb;

  localparam int WINDOW        = 10;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 1600;
  localparam int PHASES        = 6;
  localparam int PLAN_LEN      = 23;

  typedef struct packed {
    logic [frm_pkg::RATE_W-1:0]  rate_q8;
    logic [frm_pkg::DELAY_W-1:0] delay_ms;
    logic [frm_pkg::TS_W-1:0]    frame_time_ms;
  } frame_report_t;

  typedef enum logic {ROW_MARK, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e                  kind;
    logic                       op;
    logic [frm_pkg::TS_W-1:0]   ts;
    logic [frm_pkg::MAXR_W-1:0] rate_limit;
    bit                         typed;
    frame_report_t              report;
  } plan_row_t;

  // DUT connections
  logic                        clk_i          = 1'b0;
  logic                        rst_ni         = 1'b0;
  logic                        cfg_we_i       = 1'b0;
  logic [frm_pkg::MAXR_W-1:0]  cfg_wdata_i    = '0;
  logic                        in_valid_i     = 1'b0;
  logic                        operation_i    = frm_pkg::OP_START;
  logic [frm_pkg::TS_W-1:0]    timestamp_ms_i = '0;
  logic                        out_ready_i    = 1'b0;
  logic                        in_ready_o;
  logic                        out_valid_o;
  logic [frm_pkg::RATE_W-1:0]  rate_q8_o;
  logic [frm_pkg::DELAY_W-1:0] delay_ms_o;
  logic [frm_pkg::TS_W-1:0]    frame_time_ms_o;

  // Model of the period window
  logic [frm_pkg::TS_W-1:0]    period_ring [WINDOW];
  int unsigned                 ring_slot    = 0;
  int unsigned                 ring_count   = 0;
  longint unsigned             ring_sum     = 0;
  logic [frm_pkg::TS_W-1:0]    last_end_ms  = '0;
  logic [frm_pkg::TS_W-1:0]    start_ms     = '0;
  bit                          end_seen     = 1'b0;
  logic [frm_pkg::MAXR_W-1:0]  max_rate_cfg = frm_pkg::MAX_RATE_RST;

  frame_report_t      pending_reports [$];
  int                 error_count = 0;
  int                 sent_items  = 0;
  int                 cycle_count = 0;
  int                 stall_left  = 0;
  bit                 calm        = 1'b0;

  // Directed marks; only the first end marks carry typed-in results
  plan_row_t directed_plan [PLAN_LEN] = '{
    // first end with no start: period 0, zero sum, elapsed from time 0
    '{ROW_MARK, frm_pkg::OP_END, 32'd5, 10'd0, 1'b1, '{frm_pkg::RATE_DEFAULT, 10'd11, 32'd0}},
    // second zero period keeps the sum at zero
    '{ROW_MARK, frm_pkg::OP_END, 32'd5, 10'd0, 1'b1, '{frm_pkg::RATE_DEFAULT, 10'd11, 32'd0}},
    '{ROW_MARK, frm_pkg::OP_START, 32'd100,       10'd0,    1'b0, '0},
    '{ROW_MARK, frm_pkg::OP_END,   32'd100,       10'd0,    1'b0, '0},
    // wrap of the tick count between start and end
    '{ROW_MARK, frm_pkg::OP_START, 32'hFFFF_FFF0, 10'd0,    1'b0, '0},
    '{ROW_MARK, frm_pkg::OP_END,   32'h0000_000A, 10'd0,    1'b0, '0},
    '{ROW_MARK, frm_pkg::OP_END,   32'hFFFF_FFFF, 10'd0,    1'b0, '0},
    '{ROW_MARK, frm_pkg::OP_START, 32'd0,         10'd0,    1'b0, '0},
    '{ROW_MARK, frm_pkg::OP_END,   32'd0,         10'd0,    1'b0, '0},
    // zero max_rate acts as one
    '{ROW_CFG,  frm_pkg::OP_START, 32'd0,         10'd0,    1'b0, '0},
    '{ROW_MARK, frm_pkg::OP_START, 32'd1000,      10'd0,    1'b0, '0},
    '{ROW_MARK, frm_pkg::OP_END,   32'd1000,      10'd0,    1'b0, '0},
    '{ROW_CFG,  frm_pkg::OP_START, 32'd0,         10'd1000, 1'b0, '0},
    '{ROW_MARK, frm_pkg::OP_START, 32'd50,        10'd0,    1'b0, '0},
    '{ROW_MARK, frm_pkg::OP_END,   32'd50,        10'd0,    1'b0, '0},
    // above 1000 the target period floors to zero
    '{ROW_CFG,  frm_pkg::OP_START, 32'd0,         10'd1023, 1'b0, '0},
    '{ROW_MARK, frm_pkg::OP_START, 32'd7,         10'd0,    1'b0, '0},
    '{ROW_MARK, frm_pkg::OP_END,   32'd7,         10'd0,    1'b0, '0},
    '{ROW_CFG,  frm_pkg::OP_START, 32'd0,         10'd1,    1'b0, '0},
    '{ROW_MARK, frm_pkg::OP_START, 32'd0,         10'd0,    1'b0, '0},
    '{ROW_MARK, frm_pkg::OP_END,   32'd999,       10'd0,    1'b0, '0},
    // elapsed equal to the target period
    '{ROW_MARK, frm_pkg::OP_END,   32'd1000,      10'd0,    1'b0, '0},
    '{ROW_CFG,  frm_pkg::OP_START, 32'd0,         10'd60,   1'b0, '0}
  };

  frame_rate_meter_and_limiter #(
    .WINDOW (WINDOW)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .timestamp_ms_i  (timestamp_ms_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .rate_q8_o       (rate_q8_o),
    .delay_ms_o      (delay_ms_o),
    .frame_time_ms_o (frame_time_ms_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("frame_rate_meter_and_limiter verification failed");
      $finish;
    end
  end

  // Model of one mark: updates window state, returns the report of an end mark
  task automatic predict_frame(input logic op, input logic [frm_pkg::TS_W-1:0] now,
                               output bit emits, output frame_report_t rep);
    logic [frm_pkg::TS_W-1:0] period;
    logic [frm_pkg::TS_W-1:0] elapsed;
    logic [frm_pkg::TS_W-1:0] target;
    longint unsigned          quot;
    emits = 1'b0;
    rep   = '0;
    if (op == frm_pkg::OP_START) begin
      start_ms = now;
    end else begin
      period      = end_seen ? now - last_end_ms : '0;
      end_seen    = 1'b1;
      last_end_ms = now;
      // oldest period drops out once the window is full
      if (ring_count >= WINDOW) begin
        ring_sum = ring_sum - period_ring[ring_slot];
      end else begin
        ring_count++;
      end
      period_ring[ring_slot] = period;
      ring_sum  = ring_sum + period;
      ring_slot = (ring_slot + 1 >= WINDOW) ? 0 : ring_slot + 1;
      if (ring_sum == 0) begin
        rep.rate_q8 = frm_pkg::RATE_DEFAULT;
      end else begin
        quot = (longint'(ring_count) * frm_pkg::RATE_SCALE) / ring_sum;
        rep.rate_q8 = (quot > frm_pkg::RATE_MAX) ? frm_pkg::RATE_MAX
                                                 : quot[frm_pkg::RATE_W-1:0];
      end
      target  = frm_pkg::TGT_NUM / ((max_rate_cfg == 0) ? 1 : max_rate_cfg);
      elapsed = now - start_ms;
      rep.delay_ms      = (elapsed < target) ? frm_pkg::DELAY_W'(target - elapsed) : '0;
      rep.frame_time_ms = period;
      emits = 1'b1;
    end
  endtask

  // Sender gap: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // One request on the input channel, predicted when accepted
  task automatic send_mark(input logic op, input logic [frm_pkg::TS_W-1:0] ts,
                           input bit typed, input frame_report_t typed_report);
    int            gap;
    bit            emits;
    frame_report_t predicted;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    timestamp_ms_i <= ts;
    do @(posedge clk_i); while (!in_ready_o);
    predict_frame(op, ts, emits, predicted);
    if (emits) pending_reports.push_back(typed ? typed_report : predicted);
    sent_items++;
  endtask

  // Hold the sender until every report is back and the block is idle
  task automatic drain_reports();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_max_rate(input logic [frm_pkg::MAXR_W-1:0] value);
    drain_reports();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    max_rate_cfg = value;
  endtask

  // Receiver: random stalls, short mostly, a few long
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < 20) begin
      out_ready_i <= 1'b0;
      stall_left  <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                   : $urandom_range(10, 40);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk_i) begin : check_reports
    frame_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report rate_q8=%0d delay_ms=%0d frame_time_ms=%0d",
                 $time, rate_q8_o, delay_ms_o, frame_time_ms_o);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        if (rate_q8_o !== want.rate_q8) begin
          $display("%0t: rate_q8 expected %0d actual %0d",
                   $time, want.rate_q8, rate_q8_o);
          error_count++;
        end
        if (delay_ms_o !== want.delay_ms) begin
          $display("%0t: delay_ms expected %0d actual %0d",
                   $time, want.delay_ms, delay_ms_o);
          error_count++;
        end
        if (frame_time_ms_o !== want.frame_time_ms) begin
          $display("%0t: frame_time_ms expected %0d actual %0d",
                   $time, want.frame_time_ms, frame_time_ms_o);
          error_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    logic [frm_pkg::TS_W-1:0] clock_ms;
    logic [frm_pkg::TS_W-1:0] work_ms;
    int                       mode;
    int                       base_items;
    int                       burst;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CFG) begin
        write_max_rate(directed_plan[i].rate_limit);
      end else begin
        send_mark(directed_plan[i].op, directed_plan[i].ts,
                  directed_plan[i].typed, directed_plan[i].report);
      end
    end

    // random phases, one max_rate each
    clock_ms   = 32'd2000;
    base_items = sent_items;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1:       write_max_rate(10'd0);
        2:       write_max_rate(10'd1000);
        3:       write_max_rate(10'd1023);
        4:       write_max_rate(frm_pkg::MAXR_W'($urandom_range(1, 1000)));
        5:       write_max_rate(10'd1);
        default: ;
      endcase
      calm = (p == 2);
      while (sent_items < base_items + (p + 1) * RANDOM_ITEMS / PHASES) begin
        mode = $urandom_range(0, 99);
        if (mode < 70) begin
          // well-formed frame: start, some work, end
          clock_ms = clock_ms + $urandom_range(0, 40);
          send_mark(frm_pkg::OP_START, clock_ms, 1'b0, '0);
          work_ms = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1200)
                                                : $urandom_range(0, 30);
          clock_ms = clock_ms + work_ms;
          send_mark(frm_pkg::OP_END, clock_ms, 1'b0, '0);
        end else if (mode < 76) begin
          // zero periods until the window sum can reach zero
          burst = $urandom_range(10, 13);
          repeat (burst) send_mark(frm_pkg::OP_END, clock_ms, 1'b0, '0);
        end else if (mode < 80) begin
          // jump close to the tick wrap
          clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 60);
        end else if (mode < 92) begin
          send_mark(logic'($urandom_range(0, 1)), $urandom, 1'b0, '0);
        end else begin
          // end mark with a stale start
          clock_ms = clock_ms + $urandom_range(1, 3000);
          send_mark(frm_pkg::OP_END, clock_ms, 1'b0, '0);
        end
        if ($urandom_range(0, 199) == 0) drain_reports();
      end
    end

    drain_reports();
    if (error_count == 0) begin
      $display("frame_rate_meter_and_limiter verification clean");
    end else begin
      $display("frame_rate_meter_and_limiter verification failed");
    end
    $finish;
  end

endmodule
